FILE: hw/rtl/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg: shared definitions for the tuning word search
// constants, reference tables and the controller to datapath command struct
// ----------------------------------------------------------------------------
package pts_pkg;

	localparam int FREQ_W    = 30;
	localparam int CHAN_W    = 32;
	localparam int WORD_W    = 24;
	localparam int SEP_W     = 10;
	localparam int DIVR_W    = 4;
	localparam int ERR_W     = 31;
	localparam int REF_W     = 22;
	localparam int CORR_W    = 12;
	localparam int QUO_W     = 32;
	localparam int STEP_W    = 5;
	localparam int IDX_W     = 4;

	localparam int NUM_REFS_DEF = 9;
	localparam int TABLE_LEN    = 9;

	localparam logic [31:0] IF_HZ        = 32'd150000;
	localparam logic [31:0] WORD_MIN     = 32'd4194304;
	localparam logic [31:0] WORD_MAX     = 32'd16751615;
	localparam logic [31:0] HALF_STEP    = 32'd8192;
	localparam logic [ERR_W-1:0] NO_ERR  = 31'h7fffffff;
	localparam logic [DIVR_W-1:0] DIV_BASE = 4'd6;

	typedef struct packed {
		logic             load_item;
		logic             load_div;
		logic             div_step;
		logic             eval;
		logic             compare;
		logic             publish;
		logic [IDX_W-1:0] ref_idx;
	} pts_cmd_t;

	function automatic logic [REF_W-1:0] ref_hz(input logic [IDX_W-1:0] idx);
		logic [REF_W-1:0] r;
		case (idx)
			4'd0:    r = 22'd2457600;
			4'd1:    r = 22'd2106514;
			4'd2:    r = 22'd1843200;
			4'd3:    r = 22'd1638400;
			4'd4:    r = 22'd1474560;
			4'd5:    r = 22'd1340509;
			4'd6:    r = 22'd1228800;
			4'd7:    r = 22'd1134277;
			4'd8:    r = 22'd1053257;
			default: r = 22'd1053257;
		endcase
		return r;
	endfunction

	function automatic logic [CORR_W-1:0] corr_word(input logic [IDX_W-1:0] idx);
		logic [CORR_W-1:0] c;
		case (idx)
			4'd0:    c = 12'd1213;
			4'd1:    c = 12'd1416;
			4'd2:    c = 12'd1618;
			4'd3:    c = 12'd1820;
			4'd4:    c = 12'd2022;
			4'd5:    c = 12'd2224;
			4'd6:    c = 12'd2427;
			4'd7:    c = 12'd2629;
			4'd8:    c = 12'd2831;
			default: c = 12'd2831;
		endcase
		return c;
	endfunction

	function automatic logic [SEP_W-1:0] sep_word(input logic [IDX_W-1:0] idx);
		logic [SEP_W-1:0] s;
		case (idx)
			4'd0:    s = 10'h1AA;
			4'd1:    s = 10'h1F1;
			4'd2:    s = 10'h238;
			4'd3:    s = 10'h280;
			4'd4:    s = 10'h2C7;
			4'd5:    s = 10'h30E;
			4'd6:    s = 10'h355;
			4'd7:    s = 10'h39C;
			4'd8:    s = 10'h3E3;
			default: s = 10'h3E3;
		endcase
		return s;
	endfunction

endpackage

FILE: hw/rtl/pts_if.sv
// ----------------------------------------------------------------------------
// pts_if: request channels of the tuning word search
// input channel carries the wanted frequency, output channel the result
// ----------------------------------------------------------------------------
interface pts_in_if import pts_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FREQ_W-1:0] desired_freq;

	modport source (output valid, output desired_freq, input ready);
	modport sink   (input valid, input desired_freq, output ready);
endinterface

interface pts_out_if import pts_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] actual_freq;
	logic [WORD_W-1:0] rx_word;
	logic [WORD_W-1:0] tx_word;
	logic [SEP_W-1:0]  separation_word;
	logic [DIVR_W-1:0] ref_divider;
	logic [ERR_W-1:0]  freq_error;
	logic              found;

	modport source (output valid, output actual_freq, output rx_word, output tx_word,
		output separation_word, output ref_divider, output freq_error, output found,
		input ready);
	modport sink (input valid, input actual_freq, input rx_word, input tx_word,
		input separation_word, input ref_divider, input freq_error, input found,
		output ready);
endinterface

FILE: hw/rtl/pll_tuning_word_search.sv
// ----------------------------------------------------------------------------
// pll_tuning_word_search: synthesizer tuning word search
// finds the reference giving the closest channel with words in range
// ----------------------------------------------------------------------------
//
// channel   modport  payload                                     request
// in_ch     sink     desired_freq                                wanted carrier
// out_ch    source   actual_freq rx_word tx_word separation_word one result
//                    ref_divider freq_error found
//
// each request runs the 32-step bit-serial divider once per reference,
// one divider shared by all references
// the output register holds one result, so a new request is accepted while
// the previous result still waits; finishing stalls until that slot is free
// asynchronous reset clears the sequencer and the output valid only
//
module pll_tuning_word_search import pts_pkg::*; #(
	parameter int NUM_REFS = NUM_REFS_DEF
) (
	input logic     clk,
	input logic     arst_n,
	pts_in_if.sink  in_ch,
	pts_out_if.source out_ch
);

	pts_cmd_t cmd;

	// sequencer: reference index, divider step and handshakes
	pts_ctrl #(
		.NUM_REFS (NUM_REFS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd)
	);

	// datapath: division, word forming, best-candidate and result registers
	pts_dpath u_dpath (
		.clk             (clk),
		.cmd             (cmd),
		.desired_freq    (in_ch.desired_freq),
		.actual_freq     (out_ch.actual_freq),
		.rx_word         (out_ch.rx_word),
		.tx_word         (out_ch.tx_word),
		.separation_word (out_ch.separation_word),
		.ref_divider     (out_ch.ref_divider),
		.freq_error      (out_ch.freq_error),
		.found           (out_ch.found)
	);

endmodule

FILE: hw/rtl/pts_ctrl.sv
// ----------------------------------------------------------------------------
// pts_ctrl: sequencer of the tuning word search
// steps through the references, the divider bits and the output handshake
// ----------------------------------------------------------------------------
module pts_ctrl import pts_pkg::*; #(
	parameter int NUM_REFS = NUM_REFS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output pts_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_MUL,
		S_CMP,
		S_FINISH
	} state_t;

	localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(NUM_REFS - 1);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUO_W - 1);

	state_t            state_q;
	logic [IDX_W-1:0]  idx_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic              slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.ref_idx   = idx_q;
		case (state_q)
			S_IDLE: begin
				cmd.load_item = in_valid;
				cmd.load_div  = in_valid;
			end
			S_DIV:    cmd.div_step = 1'b1;
			S_MUL:    cmd.eval     = 1'b1;
			S_CMP: begin
				cmd.compare  = 1'b1;
				cmd.load_div = (idx_q != LAST_IDX);
			end
			S_FINISH: cmd.publish  = slot_free;
			default:  cmd          = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// new result fills the slot, otherwise a taken result empties it
			if (state_q == S_FINISH && slot_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						idx_q   <= '0;
						step_q  <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP)
						state_q <= S_MUL;
				end
				S_MUL: state_q <= S_CMP;
				S_CMP: begin
					step_q <= '0;
					if (idx_q == LAST_IDX) begin
						state_q <= S_FINISH;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_DIV;
					end
				end
				S_FINISH: begin
					if (slot_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: hw/rtl/pts_dpath.sv
// ----------------------------------------------------------------------------
// pts_dpath: arithmetic of the tuning word search
// bit-serial divider, word forming, error compare and result registers
// ----------------------------------------------------------------------------
module pts_dpath import pts_pkg::*; (
	input  logic              clk,
	input  pts_cmd_t          cmd,
	input  logic [FREQ_W-1:0] desired_freq,
	output logic [CHAN_W-1:0] actual_freq,
	output logic [WORD_W-1:0] rx_word,
	output logic [WORD_W-1:0] tx_word,
	output logic [SEP_W-1:0]  separation_word,
	output logic [DIVR_W-1:0] ref_divider,
	output logic [ERR_W-1:0]  freq_error,
	output logic              found
);

	logic [FREQ_W-1:0] want_q;
	logic [REF_W-1:0]  rem_q;
	logic [QUO_W-1:0]  quo_q;

	// evaluation stage
	logic [31:0]       prod_q;
	logic              half_q;
	logic [31:0]       rx_q;
	logic [31:0]       tx_q;
	logic              ok_q;

	// running best
	logic [ERR_W-1:0]  best_err_q;
	logic [31:0]       best_chan_q;
	logic [WORD_W-1:0] best_rx_q;
	logic [WORD_W-1:0] best_tx_q;
	logic [SEP_W-1:0]  best_sep_q;
	logic [DIVR_W-1:0] best_div_q;

	logic [REF_W-1:0]  ref_c;
	logic [FREQ_W-1:0] want_src;
	logic [30:0]       sum_c;
	logic [QUO_W-1:0]  dividend_c;
	logic [REF_W:0]    shifted_c;
	logic              ge_c;
	logic [12:0]       n_c;
	logic [12:0]       n_r_c;
	logic [10:0]       whole_c;
	logic [31:0]       rx_c;
	logic [31:0]       tx_c;
	logic [31:0]       chan_c;
	logic [31:0]       diff_c;
	logic [31:0]       mag_c;
	logic [ERR_W-1:0]  mag31_c;
	logic              win_c;

	assign ref_c      = ref_hz(cmd.ref_idx);
	assign want_src   = cmd.load_item ? desired_freq : want_q;
	assign sum_c      = {1'b0, want_src} + IF_HZ[30:0];
	assign dividend_c = {sum_c[29:0], 2'b00};

	// one quotient bit per step
	assign shifted_c  = {rem_q, quo_q[QUO_W-1]};
	assign ge_c       = (shifted_c >= {1'b0, ref_c});

	// round to even count, keep half step in bit one
	assign n_c     = quo_q[12:0];
	assign n_r_c   = n_c + {12'd0, n_c[0]};
	assign whole_c = n_r_c[12:2];
	assign rx_c    = {7'd0, whole_c, 14'd0} - HALF_STEP + (n_r_c[1] ? HALF_STEP : 32'd0);
	assign tx_c    = rx_c - {20'd0, corr_word(cmd.ref_idx)};

	assign chan_c  = prod_q + (half_q ? {11'd0, ref_c[REF_W-1:1]} : 32'd0) - IF_HZ;
	assign diff_c  = chan_c - {2'b00, want_q};
	assign mag_c   = diff_c[31] ? (32'd0 - diff_c) : diff_c;
	assign mag31_c = mag_c[31] ? NO_ERR : mag_c[ERR_W-1:0];
	assign win_c   = ok_q && (mag31_c < best_err_q);

	always_ff @(posedge clk) begin
		if (cmd.load_item)
			want_q <= desired_freq;

		if (cmd.load_div) begin
			rem_q <= '0;
			quo_q <= dividend_c;
		end else if (cmd.div_step) begin
			rem_q <= ge_c ? REF_W'(shifted_c - {1'b0, ref_c}) : shifted_c[REF_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], ge_c};
		end

		if (cmd.eval) begin
			prod_q <= {21'd0, whole_c} * {10'd0, ref_c};
			half_q <= n_r_c[1];
			rx_q   <= rx_c;
			tx_q   <= tx_c;
			ok_q   <= (rx_c >= WORD_MIN) && (rx_c <= WORD_MAX) &&
				(tx_c >= WORD_MIN) && (tx_c <= WORD_MAX);
		end

		if (cmd.load_item) begin
			best_err_q  <= NO_ERR;
			best_chan_q <= '0;
			best_rx_q   <= '0;
			best_tx_q   <= '0;
			best_sep_q  <= '0;
			best_div_q  <= '0;
		end else if (cmd.compare && win_c) begin
			best_err_q  <= mag31_c;
			best_chan_q <= chan_c;
			best_rx_q   <= rx_q[WORD_W-1:0];
			best_tx_q   <= tx_q[WORD_W-1:0];
			best_sep_q  <= sep_word(cmd.ref_idx);
			best_div_q  <= cmd.ref_idx + DIV_BASE;
		end

		if (cmd.publish) begin
			actual_freq     <= best_chan_q;
			rx_word         <= best_rx_q;
			tx_word         <= best_tx_q;
			separation_word <= best_sep_q;
			ref_divider     <= best_div_q;
			freq_error      <= best_err_q;
			found           <= (best_div_q != '0);
		end
	end

endmodule

FILE: bench/tb_pll_tuning_word_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pll_tuning_word_search: self-checking bench for the tuning word search
// drives wanted carrier frequencies, predicts the best reference, words and
// channel error in the bench itself and compares every returned request
// ----------------------------------------------------------------------------
module tb_pll_tuning_word_search;
	import pts_pkg::*;

	// timing and length of the run
	localparam int CLK_HALF    = 5;
	localparam int RESET_CYC   = 9;
	localparam int HOLD_CYC    = 3000;   // long receiver hold-off
	localparam int STUCK_LIMIT = 20000;  // cycles with no handshake at all
	localparam int TAIL_CYC    = 400;    // idle run after the last result is checked
	localparam int PHASE_ITEMS = 367;    // three phases of random requests
	localparam int MAX_REPORTS = 40;

	// synthesizer constants kept apart from the design
	localparam logic [31:0] TUNE_STEP = 32'd16384;
	localparam logic [31:0] ERR_CLAMP = 32'h7fffffff;

	localparam logic [31:0] REF_TABLE [TABLE_LEN] = '{
		32'd2457600, 32'd2106514, 32'd1843200, 32'd1638400, 32'd1474560,
		32'd1340509, 32'd1228800, 32'd1134277, 32'd1053257};
	localparam logic [31:0] TX_OFFSET [TABLE_LEN] = '{
		32'd1213, 32'd1416, 32'd1618, 32'd1820, 32'd2022,
		32'd2224, 32'd2427, 32'd2629, 32'd2831};
	localparam logic [SEP_W-1:0] SEP_TABLE [TABLE_LEN] = '{
		10'h1AA, 10'h1F1, 10'h238, 10'h280, 10'h2C7,
		10'h30E, 10'h355, 10'h39C, 10'h3E3};

	typedef struct packed {
		logic [CHAN_W-1:0] actual_freq;
		logic [WORD_W-1:0] rx_word;
		logic [WORD_W-1:0] tx_word;
		logic [SEP_W-1:0]  separation_word;
		logic [DIVR_W-1:0] ref_divider;
		logic [ERR_W-1:0]  freq_error;
		logic              found;
	} tuning_t;

	// predicted tunings in request order, checked against the output channel
	class tuning_scoreboard;
		tuning_t pending[$];
		int      errors;

		function new();
			errors = 0;
		endfunction

		// walk every reference and keep the closest channel with both words in range
		function tuning_t search_tuning(logic [FREQ_W-1:0] freq);
			logic [31:0] want, steps, rx, tx, chan, whole, diff, mag, best_err;
			tuning_t     best;
			best = '0;
			best.freq_error = NO_ERR;
			best_err = ERR_CLAMP;
			want = {{(32-FREQ_W){1'b0}}, freq};
			for (int k = 0; k < NUM_REFS_DEF; k++) begin
				// scaled sum wraps at 32 bits before the divide
				steps = ((want + IF_HZ) << 2) / REF_TABLE[k];
				rx = '0;
				chan = '0;
				if (steps[0])
					steps = steps + 32'd1;
				// half step kept after rounding
				if (steps[1]) begin
					rx = HALF_STEP;
					chan = REF_TABLE[k] >> 1;
				end
				whole = steps >> 2;
				rx = rx + whole * TUNE_STEP - HALF_STEP;
				if (rx < WORD_MIN || rx > WORD_MAX)
					continue;
				tx = rx - TX_OFFSET[k];
				if (tx < WORD_MIN || tx > WORD_MAX)
					continue;
				chan = chan + whole * REF_TABLE[k] - IF_HZ;
				diff = chan - want;
				mag = diff[31] ? (32'd0 - diff) : diff;
				// a magnitude of 2^31 saturates and so can never win
				if (mag > ERR_CLAMP)
					mag = ERR_CLAMP;
				// strict compare, the earlier reference keeps a tie
				if (mag < best_err) begin
					best_err = mag;
					best.actual_freq = chan;
					best.rx_word = rx[WORD_W-1:0];
					best.tx_word = tx[WORD_W-1:0];
					best.separation_word = SEP_TABLE[k];
					best.ref_divider = DIV_BASE + DIVR_W'(k);
					best.freq_error = mag[ERR_W-1:0];
					best.found = 1'b1;
				end
			end
			return best;
		endfunction

		function void note_request(logic [FREQ_W-1:0] freq);
			pending.push_back(search_tuning(freq));
		endfunction

		function void compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
			if (want_v !== got_v) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: %s mismatch, expected %0d actual %0d",
						$time, name, want_v, got_v);
			end
		endfunction

		function void check_result(tuning_t got);
			tuning_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: result with no request outstanding, expected none actual %h",
						$time, got);
				return;
			end
			want = pending.pop_front();
			compare_field("actual_freq", want.actual_freq, got.actual_freq);
			compare_field("rx_word", 32'(want.rx_word), 32'(got.rx_word));
			compare_field("tx_word", 32'(want.tx_word), 32'(got.tx_word));
			compare_field("separation_word", 32'(want.separation_word),
				32'(got.separation_word));
			compare_field("ref_divider", 32'(want.ref_divider), 32'(got.ref_divider));
			compare_field("freq_error", 32'(want.freq_error), 32'(got.freq_error));
			compare_field("found", 32'(want.found), 32'(got.found));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	pts_in_if  in_ch();
	pts_out_if out_ch();

	pll_tuning_word_search dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	tuning_scoreboard tunings;
	int               in_idle_pct;
	int               out_idle_pct;
	bit               hold_off;
	int               stuck_cycles;

	always #CLK_HALF clk = ~clk;

	// offer one wanted frequency, with random idle cycles ahead of it
	task automatic send_request(logic [FREQ_W-1:0] freq);
		while ($urandom_range(99) < in_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.desired_freq <= freq;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		tunings.note_request(freq);
	endtask

	// mostly the band where some reference gives legal words, the rest anywhere
	task automatic send_random(int count);
		logic [FREQ_W-1:0] freq;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(9) < 2)
				freq = FREQ_W'($urandom());
			else
				freq = FREQ_W'($urandom_range(30'h3fffffff, 200_000_000));
			send_request(freq);
		end
	endtask

	// receiver: random ready, with one long hold-off when asked
	initial begin
		tuning_t got;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_off) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYC) @(posedge clk);
				hold_off = 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
				@(posedge clk);
				if (out_ch.valid && out_ch.ready) begin
					got.actual_freq = out_ch.actual_freq;
					got.rx_word = out_ch.rx_word;
					got.tx_word = out_ch.tx_word;
					got.separation_word = out_ch.separation_word;
					got.ref_divider = out_ch.ref_divider;
					got.freq_error = out_ch.freq_error;
					got.found = out_ch.found;
					tunings.check_result(got);
				end
			end
		end
	end

	// watchdog on cycles with no request moving on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("tb_pll_tuning_word_search: errors");
			$finish;
		end
	end

	initial begin
		tunings = new();
		hold_off = 1'b0;
		stuck_cycles = 0;
		in_idle_pct = 29;
		out_idle_pct = 80;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.desired_freq <= '0;
		repeat (RESET_CYC) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, no legal reference, wrap of the scaled sum
		send_request(30'd0);
		send_request(30'd1);
		send_request(30'h3fffffff);
		send_request(30'h3fffffff - 30'd150000);
		send_request(30'h3fffffff - 30'd150001);
		send_request(30'h2aaaaaaa);
		send_request(30'h15555555);
		send_request(30'd100_000_000);
		// lower and upper edges of the legal word range
		send_request(30'd268_000_000);
		send_request(30'd269_500_000);
		send_request(30'd270_000_000);
		send_request(30'd627_000_000);
		send_request(30'd629_000_000);
		send_request(30'd1_000_000_000);
		send_request(30'd1_073_000_000);
		// common carriers and exact reference multiples
		send_request(30'd315_000_000);
		send_request(30'd433_920_000);
		send_request(30'd868_000_000);
		send_request(30'd915_000_000);
		send_request(30'd2457600 * 30'd300 - 30'd150000);
		send_request(30'd1228800 * 30'd500 - 30'd150000);
		send_request(30'd1053257 * 30'd400 + 30'd526628 - 30'd150000);

		send_random(PHASE_ITEMS);

		in_idle_pct = 80;
		out_idle_pct = 29;
		send_random(PHASE_ITEMS);

		// no idling; the receiver holds off while requests keep coming
		in_idle_pct = 0;
		out_idle_pct = 0;
		hold_off = 1'b1;
		send_random(6);
		send_random(PHASE_ITEMS - 6);

		in_ch.valid <= 1'b0;
		while (tunings.pending.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYC) @(posedge clk);

		if (tunings.errors == 0 && tunings.pending.size() == 0)
			$display("tb_pll_tuning_word_search: clean");
		else
			$display("tb_pll_tuning_word_search: errors");
		$finish;
	end

endmodule
